// File: hw/rtl/rfsm_pkg.sv
package rfsm_pkg;

   localparam int LANES          = 8;
   localparam int WORD_BITS      = 64;
   localparam int VALUE_W        = 64;
   localparam int ROW_W          = 32;
   localparam int TOTAL_W        = 33;
   localparam int ITEMS_PER_WORD = ((WORD_BITS / LANES) > 0) ? (WORD_BITS / LANES) : 1;
   localparam int GROUP_W        = (ITEMS_PER_WORD > 1) ? $clog2(ITEMS_PER_WORD) : 1;
   localparam int SHIFT_W        = $clog2(WORD_BITS);
   localparam int COUNT_W        = $clog2(LANES + 1);
   localparam int QUEUE_DEPTH    = 4;

   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT  = 2'd2;

   localparam logic [VALUE_W-1:0] LOW_LIMIT_RESET  = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] HIGH_LIMIT_RESET = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef struct packed {
      logic signed [VALUE_W-1:0] low_limit;
      logic signed [VALUE_W-1:0] high_limit;
      logic [ROW_W-1:0]          row_count;
   } cfg_type;

   typedef struct packed {
      logic [LANES-1:0] kept;
      logic             end_mark;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hw/rtl/rfsm_channels.sv
interface rfsm_req_if;
   import rfsm_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value_0;
   logic signed [VALUE_W-1:0] value_1;
   logic signed [VALUE_W-1:0] value_2;
   logic signed [VALUE_W-1:0] value_3;
   logic signed [VALUE_W-1:0] value_4;
   logic signed [VALUE_W-1:0] value_5;
   logic signed [VALUE_W-1:0] value_6;
   logic signed [VALUE_W-1:0] value_7;
   logic [LANES-1:0]          select_bits;
   logic [LANES-1:0]          valid_bits;
   logic [ROW_W-1:0]          base_row;
   logic                      end_mark;

   modport source (
      output valid, value_0, value_1, value_2, value_3, value_4, value_5, value_6, value_7,
      output select_bits, valid_bits, base_row, end_mark,
      input  ready
   );
   modport sink (
      input  valid, value_0, value_1, value_2, value_3, value_4, value_5, value_6, value_7,
      input  select_bits, valid_bits, base_row, end_mark,
      output ready
   );
endinterface

interface rfsm_rsp_if;
   import rfsm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] kept_word;
   logic [TOTAL_W-1:0]   kept_total;
   logic                 call_done;

   modport source (output valid, kept_word, kept_total, call_done, input ready);
   modport sink   (input valid, kept_word, kept_total, call_done, output ready);
endinterface

// File: hw/rtl/range_filter_selection_mask_core.sv
// A word leaves on rsp once the item that closes it has passed the lane compare into the queue
//   and has then been accumulated into the output register.
// Throughput: one item per cycle while rsp is not stalled; the back-end accumulate step sets it.
// Items that do not close a word produce no transfer on rsp.
// Reset (synchronous, active high) empties the queue, clears the partial word, group index
//   and running count, and restores the bounds and row count to their reset values.
module range_filter_selection_mask_core #(
   parameter int QUEUE_DEPTH = rfsm_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rfsm_req_if.sink                             req,
   rfsm_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [rfsm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rfsm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rfsm_pkg::*;

   // configuration registers; the user writes them only while idle, the block does not enforce it
   logic [VALUE_W-1:0] lower_ff, lower_in;
   logic [VALUE_W-1:0] upper_ff, upper_in;
   logic [ROW_W-1:0]   rows_ff, rows_in;

   cfg_type      cfg;
   push_type     push;
   entry_type    head;
   q_status_type q_status;
   logic         pop;

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      rows_in  = rows_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LOW_LIMIT:  lower_in = csr_wdata[VALUE_W-1:0];
            REG_HIGH_LIMIT: upper_in = csr_wdata[VALUE_W-1:0];
            REG_ROW_COUNT:  rows_in  = csr_wdata[ROW_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= LOW_LIMIT_RESET;
         upper_ff <= HIGH_LIMIT_RESET;
         rows_ff  <= '0;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         rows_ff  <= rows_in;
      end
   end

   assign cfg.low_limit  = lower_ff;
   assign cfg.high_limit = upper_ff;
   assign cfg.row_count  = rows_ff;

   // front: classify every lane of the incoming item and push the kept bits
   rfsm_front u_front (
      .cfg      (cfg),
      .req      (req),
      .q_status (q_status),
      .push     (push)
   );

   // short queue decouples front stalls from the output side
   rfsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   // back: pack kept bits into the word, count, and hold the result for transfer
   rfsm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

// File: hw/rtl/rfsm_front.sv
module rfsm_front (
   input  rfsm_pkg::cfg_type      cfg,
   rfsm_req_if.sink               req,
   input  rfsm_pkg::q_status_type q_status,
   output rfsm_pkg::push_type     push
);
   import rfsm_pkg::*;

   logic signed [VALUE_W-1:0] lane_value [LANES];
   logic [LANES-1:0]          keep;

   assign lane_value[0] = req.value_0;
   assign lane_value[1] = req.value_1;
   assign lane_value[2] = req.value_2;
   assign lane_value[3] = req.value_3;
   assign lane_value[4] = req.value_4;
   assign lane_value[5] = req.value_5;
   assign lane_value[6] = req.value_6;
   assign lane_value[7] = req.value_7;

   // row number is formed one bit wider so it never wraps
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [ROW_W:0] row_num;
      assign row_num = {1'b0, req.base_row} + (ROW_W+1)'(g);
      assign keep[g] = req.select_bits[g] & req.valid_bits[g]
                     & (row_num < {1'b0, cfg.row_count})
                     & ($signed(lane_value[g]) >= $signed(cfg.low_limit))
                     & ($signed(lane_value[g]) <= $signed(cfg.high_limit));
   end

   assign req.ready          = !q_status.full;
   assign push.valid         = req.valid & !q_status.full;
   assign push.entry.kept    = keep;
   assign push.entry.end_mark = req.end_mark;

endmodule

// File: hw/rtl/rfsm_queue.sv
module rfsm_queue #(
   parameter int DEPTH = rfsm_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rfsm_pkg::push_type     push,
   input  logic                   pop,
   output rfsm_pkg::entry_type    head,
   output rfsm_pkg::q_status_type status
);
   import rfsm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: hw/rtl/rfsm_back.sv
module rfsm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rfsm_pkg::entry_type    head,
   input  rfsm_pkg::q_status_type q_status,
   output logic                   pop,
   rfsm_rsp_if.source             rsp
);
   import rfsm_pkg::*;

   logic [WORD_BITS-1:0] partial_ff, partial_in;
   logic [GROUP_W-1:0]   group_ff, group_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] kept_word_ff, kept_word_in;
   logic [TOTAL_W-1:0]   kept_total_ff, kept_total_in;
   logic                 call_done_ff, call_done_in;

   logic [SHIFT_W-1:0]   shift_amt;
   logic [WORD_BITS-1:0] word_new;
   logic [COUNT_W-1:0]   kept_cnt;
   logic [TOTAL_W:0]     total_sum;
   logic [TOTAL_W-1:0]   total_new;
   logic                 last;

   assign pop = !q_status.empty && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      kept_cnt = '0;
      for (int i = 0; i < LANES; i++) begin
         kept_cnt = kept_cnt + COUNT_W'(head.kept[i]);
      end
   end

   assign shift_amt = SHIFT_W'(group_ff) * SHIFT_W'(LANES);
   assign word_new  = partial_ff | (WORD_BITS'(head.kept) << shift_amt);
   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(kept_cnt);
   // saturate the count at all ones
   assign total_new = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
   assign last      = (group_ff == GROUP_W'(ITEMS_PER_WORD - 1)) || head.end_mark;

   always_comb begin
      partial_in    = partial_ff;
      group_in      = group_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff & !rsp.ready;
      kept_word_in  = kept_word_ff;
      kept_total_in = kept_total_ff;
      call_done_in  = call_done_ff;
      if (pop) begin
         if (last) begin
            partial_in    = '0;
            group_in      = '0;
            total_in      = head.end_mark ? '0 : total_new;
            rsp_valid_in  = 1'b1;
            kept_word_in  = word_new;
            kept_total_in = total_new;
            call_done_in  = head.end_mark;
         end else begin
            partial_in = word_new;
            group_in   = group_ff + 1'b1;
            total_in   = total_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         group_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         group_ff     <= group_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kept_word_ff  <= kept_word_in;
      kept_total_ff <= kept_total_in;
      call_done_ff  <= call_done_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kept_word  = kept_word_ff;
   assign rsp.kept_total = kept_total_ff;
   assign rsp.call_done  = call_done_ff;

endmodule

// File: hw/rtl/rfsm_checker.sv
module rfsm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [rfsm_pkg::WORD_BITS-1:0]      rsp_kept_word,
   input logic [rfsm_pkg::TOTAL_W-1:0]        rsp_kept_total,
   input logic                                rsp_call_done
);
   import rfsm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_kept_word) && $stable(rsp_kept_total) && $stable(rsp_call_done))
      else $error("rsp payload changed while stalled");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("queue not empty after reset");

   a_total_covers_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kept_total >= TOTAL_W'($countones(rsp_kept_word))))
      else $error("running count below kept bits of the word");

endmodule

bind range_filter_selection_mask_core rfsm_checker u_rfsm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_kept_word  (rsp.kept_word),
   .rsp_kept_total (rsp.kept_total),
   .rsp_call_done  (rsp.call_done)
);

// File: bench/range_filter_selection_mask_core_test.sv
`timescale 1ns / 100ps

module range_filter_selection_mask_core_test;
   import rfsm_pkg::*;

   localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [TOTAL_W-1:0] TALLY_MAX = '1;
   localparam int SETTLE_CYCLES = 8;     // covers the two-stage path plus queue slack
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
   localparam int BURST_ITEMS   = 40;
   localparam int PHASE_ITEMS   = 68;
   localparam int TIMEOUT_NS    = 3_000_000;

   // One scan item: eight lane values plus their masks and row position.
   typedef struct {
      logic [VALUE_W-1:0] lane_value [LANES];
      logic [LANES-1:0]   select_bits;
      logic [LANES-1:0]   valid_bits;
      logic [ROW_W-1:0]   base_row;
      logic               end_mark;
   } scan_item_type;

   // One narrowed selection word as it should leave on rsp.
   typedef struct packed {
      logic [WORD_BITS-1:0] kept_word;
      logic [TOTAL_W-1:0]   kept_total;
      logic                 call_done;
   } sel_word_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rfsm_req_if req_ch ();
   rfsm_rsp_if rsp_ch ();

   range_filter_selection_mask_core uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the bound registers.
   logic signed [VALUE_W-1:0] lo_bound  = VALUE_MIN;
   logic signed [VALUE_W-1:0] hi_bound  = VALUE_MAX;
   logic [ROW_W-1:0]          row_limit = '0;

   // Predictor copy of the accumulation state.
   logic [WORD_BITS-1:0] word_accum = '0;
   logic [TOTAL_W-1:0]   call_tally = '0;
   int                   lane_group = 0;

   scan_item_type scan_queue [$];   // items waiting for the driver
   sel_word_type  words_due  [$];   // predicted words, oldest first
   scan_item_type on_offer;         // item currently presented on req

   int items_queued   = 0;
   int items_taken    = 0;
   int words_checked  = 0;
   int calls_closed   = 0;
   int settings_used  = 0;
   int mismatch_count = 0;
   int idle_pct       = 0;
   int stall_pct      = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   task automatic log_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Narrow one accepted item against the current bounds; queue the word it closes.
   task automatic narrow_item(input scan_item_type it);
      logic [WORD_BITS-1:0] kept;
      logic [ROW_W:0]       row;
      logic [TOTAL_W:0]     sum;
      int                   pos;
      sel_word_type         w;
      kept = '0;
      for (int lane = 0; lane < LANES; lane++) begin
         pos = lane_group * LANES + lane;
         // row number is taken without wrap, so a base near the top drops upper lanes
         row = {1'b0, it.base_row} + (ROW_W + 1)'(lane);
         if (it.select_bits[lane] && it.valid_bits[lane] && row < {1'b0, row_limit}
             && $signed(it.lane_value[lane]) >= lo_bound
             && $signed(it.lane_value[lane]) <= hi_bound
             && pos < WORD_BITS) begin
            kept[pos] = 1'b1;
         end
      end
      word_accum |= kept;
      sum = {1'b0, call_tally} + (TOTAL_W + 1)'($countones(kept));
      call_tally = (sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : sum[TOTAL_W-1:0];
      lane_group++;
      if (lane_group >= ITEMS_PER_WORD || it.end_mark) begin
         w.kept_word  = word_accum;
         w.kept_total = call_tally;
         w.call_done  = it.end_mark;
         words_due.insert(words_due.size(), w);
         word_accum = '0;
         lane_group = 0;
         if (it.end_mark) call_tally = '0;
      end
   endtask

   // Driver: predict on each transfer, then present the next pending item or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            narrow_item(on_offer);
            items_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (scan_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               on_offer = scan_queue.pop_front();
               req_ch.value_0     <= on_offer.lane_value[0];
               req_ch.value_1     <= on_offer.lane_value[1];
               req_ch.value_2     <= on_offer.lane_value[2];
               req_ch.value_3     <= on_offer.lane_value[3];
               req_ch.value_4     <= on_offer.lane_value[4];
               req_ch.value_5     <= on_offer.lane_value[5];
               req_ch.value_6     <= on_offer.lane_value[6];
               req_ch.value_7     <= on_offer.lane_value[7];
               req_ch.select_bits <= on_offer.select_bits;
               req_ch.valid_bits  <= on_offer.valid_bits;
               req_ch.base_row    <= on_offer.base_row;
               req_ch.end_mark    <= on_offer.end_mark;
               req_ch.valid       <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready: random stalls, or a long hold-off counted down here when requested.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: compare every word transfer with the oldest prediction.
   always @(posedge clock) begin
      sel_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (words_due.size() == 0) begin
            log_mismatch($sformatf("unexpected word %h total %0d done %b",
                                   rsp_ch.kept_word, rsp_ch.kept_total, rsp_ch.call_done));
         end else begin
            want = words_due.pop_front();
            words_checked++;
            if (want.call_done) calls_closed++;
            if (rsp_ch.kept_word !== want.kept_word)
               log_mismatch($sformatf("kept_word %h, want %h",
                                      rsp_ch.kept_word, want.kept_word));
            if (rsp_ch.kept_total !== want.kept_total)
               log_mismatch($sformatf("kept_total %0d, want %0d",
                                      rsp_ch.kept_total, want.kept_total));
            if (rsp_ch.call_done !== want.call_done)
               log_mismatch($sformatf("call_done %b, want %b",
                                      rsp_ch.call_done, want.call_done));
         end
      end
   end

   // Write one register and mirror it in the predictor; only called while idle.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_LOW_LIMIT:  lo_bound  = data;
         REG_HIGH_LIMIT: hi_bound  = data;
         REG_ROW_COUNT:  row_limit = data[ROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_bounds(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [ROW_W-1:0] rows);
      write_reg(REG_LOW_LIMIT, lo);
      write_reg(REG_HIGH_LIMIT, hi);
      write_reg(REG_ROW_COUNT, {32'd0, rows});
      settings_used++;
   endtask

   task automatic queue_item(input scan_item_type it);
      scan_queue.insert(scan_queue.size(), it);
      items_queued++;
   endtask

   // Wait until every item is taken and every word has arrived, then let the pipe empty.
   task automatic settle();
      while (items_taken != items_queued || words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Lane value: fully random, at or next to a bound, or somewhere inside the range.
   function automatic logic [63:0] draw_value();
      logic [63:0] r;
      logic [63:0] span;
      r = {$urandom, $urandom};
      span = hi_bound - lo_bound;
      case ($urandom_range(5))
         0: return r;
         1: return lo_bound + 64'($urandom_range(2)) - 64'd1;
         2: return hi_bound + 64'($urandom_range(2)) - 64'd1;
         default: begin
            if (lo_bound > hi_bound || span == '1) return r;
            return lo_bound + (r % (span + 64'd1));
         end
      endcase
   endfunction

   function automatic logic [LANES-1:0] draw_mask();
      // lean toward set bits so most lanes reach the range compare
      if ($urandom_range(3) == 0) return LANES'($urandom);
      return LANES'($urandom | $urandom);
   endfunction

   // Queue whole narrowing calls over consecutive rows, with some stray items mixed in.
   task automatic queue_calls(input int count);
      scan_item_type it;
      int            len;
      logic [31:0]   row;
      int            done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(5) == 0) begin
            foreach (it.lane_value[l]) it.lane_value[l] = {$urandom, $urandom};
            it.select_bits = LANES'($urandom);
            it.valid_bits  = LANES'($urandom);
            it.base_row    = $urandom;
            it.end_mark    = ($urandom_range(3) == 0);
            queue_item(it);
            done++;
         end else begin
            len = $urandom_range(1, 20);
            case ($urandom_range(3))
               0:       row = $urandom;
               1:       row = row_limit - 32'($urandom_range(160));
               default: row = 32'($urandom_range(400));
            endcase
            for (int k = 0; k < len; k++) begin
               foreach (it.lane_value[l]) it.lane_value[l] = draw_value();
               it.select_bits = draw_mask();
               it.valid_bits  = draw_mask();
               it.base_row    = row;
               it.end_mark    = (k == len - 1);
               queue_item(it);
               row += LANES;
            end
            done += len;
         end
      end
   endtask

   task automatic pick_bounds(input int k);
      logic [63:0] a;
      logic [63:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case (k)
         1: set_bounds(VALUE_MIN, VALUE_MAX, 32'hFFFF_FFFF);
         2: begin
            if ($signed(a) <= $signed(b)) set_bounds(a, b, $urandom);
            else set_bounds(b, a, $urandom);
         end
         3: set_bounds(64'd0, 64'd0, 32'd600);
         4: set_bounds(a, b, 32'($urandom_range(2000)));   // may well be an empty range
         5: set_bounds(64'hFFFF_FFFF_FFFF_FFFF, VALUE_MAX, 32'd100);
         6: set_bounds(VALUE_MIN, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
         default: set_bounds(-64'sd1000, 64'sd1000, 32'd4000);
      endcase
   endtask

   // Watchdog.
   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d words still due", words_due.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      scan_item_type it;
      int idle_of  [4];
      int stall_of [4];
      idle_of  = '{0, 71, 0, 14};
      stall_of = '{0, 0, 71, 14};

      // Hold every block input at a known value before the first edge.
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.value_0     = '0;
      req_ch.value_1     = '0;
      req_ch.value_2     = '0;
      req_ch.value_3     = '0;
      req_ch.value_4     = '0;
      req_ch.value_5     = '0;
      req_ch.value_6     = '0;
      req_ch.value_7     = '0;
      req_ch.select_bits = '0;
      req_ch.valid_bits  = '0;
      req_ch.base_row    = '0;
      req_ch.end_mark    = 1'b0;
      rsp_ch.ready       = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset bounds: row count of zero drops every row; end mark on the first
      // item of a word still emits an empty word.
      it.lane_value  = '{VALUE_MIN, VALUE_MAX, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1,
                         VALUE_MIN + 64'd1, VALUE_MAX - 64'd1, 64'h0123_4567_89AB_CDEF};
      it.select_bits = 8'hFF;
      it.valid_bits  = 8'hFF;
      it.base_row    = 32'd0;
      it.end_mark    = 1'b1;
      queue_item(it);
      settle();

      // Full-range bounds, every row in the column: extremes of values and masks.
      write_reg(REG_ROW_COUNT, 64'h0000_0000_FFFF_FFFF);
      it.end_mark = 1'b0;
      queue_item(it);
      it.base_row = 32'd8;   it.select_bits = 8'h55; queue_item(it);
      it.base_row = 32'd16;  it.select_bits = 8'hFF; it.valid_bits = 8'hAA; queue_item(it);
      it.base_row = 32'd24;  it.select_bits = 8'h00; it.valid_bits = 8'hFF; queue_item(it);
      // rows at the very top of the row space: no wrap, so upper lanes fall off
      it.base_row = 32'hFFFF_FFF8; it.select_bits = 8'hFF; queue_item(it);
      it.base_row = 32'hFFFF_FFFF; queue_item(it);
      it.base_row = 32'd100; queue_item(it);
      it.base_row = 32'd108; queue_item(it);       // eighth item closes the word
      it.base_row = 32'd116; it.end_mark = 1'b1; queue_item(it);
      settle();

      // Narrow range: values right at and just past each bound.
      set_bounds(-64'sd5, 64'sd5, 32'hFFFF_FFFF);
      it.lane_value = '{-64'sd6, -64'sd5, -64'sd4, 64'sd0, 64'sd4, 64'sd5, 64'sd6, VALUE_MIN};
      it.base_row   = 32'd0;
      queue_item(it);
      settle();

      // Empty range: lower above upper keeps nothing.
      set_bounds(64'sd10, -64'sd10, 32'hFFFF_FFFF);
      it.lane_value = '{-64'sd10, -64'sd1, 64'sd0, 64'sd1, 64'sd10, 64'sd9, -64'sd9, 64'sd5};
      queue_item(it);
      settle();

      // Single-point ranges at both ends of the value space.
      it.lane_value = '{VALUE_MIN, VALUE_MAX, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1,
                        VALUE_MIN + 64'd1, VALUE_MAX - 64'd1, 64'h0123_4567_89AB_CDEF};
      set_bounds(VALUE_MAX, VALUE_MAX, 32'hFFFF_FFFF);
      it.end_mark = 1'b0; queue_item(it);
      it.end_mark = 1'b1; queue_item(it);
      settle();
      set_bounds(VALUE_MIN, VALUE_MIN, 32'd8);
      it.base_row = 32'd0; queue_item(it);
      it.base_row = 32'd1; queue_item(it);          // lane 7 lands on row 8, past the column
      settle();

      // Back-pressure: hold the receiver off while a burst of one-item calls
      // streams in, so the queue fills and req.ready drops.
      set_bounds(-64'sd1000, 64'sd1000, 32'd4000);
      idle_pct  = 0;
      stall_pct = 0;
      hold_requests++;
      for (int n = 0; n < BURST_ITEMS; n++) begin
         foreach (it.lane_value[l]) it.lane_value[l] = draw_value();
         it.select_bits = draw_mask();
         it.valid_bits  = draw_mask();
         it.base_row    = 32'($urandom_range(4100));
         it.end_mark    = 1'b1;
         queue_item(it);
      end
      settle();

      // Random calls: each idling profile runs under two bound settings; the
      // sender pauses at every boundary until all words are back.
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 2; s++) begin
            idle_pct  = idle_of[p];
            stall_pct = stall_of[p];
            pick_bounds(2 * p + s);
            queue_calls(PHASE_ITEMS);
            settle();
         end
      end

      // Let any stray word show up with the receiver wide open.
      idle_pct  = 0;
      stall_pct = 0;
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (words_due.size() != 0)
         log_mismatch($sformatf("%0d predicted words never arrived", words_due.size()));

      $display("Summary: %0d item transfers narrowed, %0d words checked (%0d closing a call)",
               items_taken, words_checked, calls_closed);
      $display("Summary: %0d bound settings, back-pressure burst and four idling profiles",
               settings_used);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: range_filter_selection_mask_core.f
hw/rtl/rfsm_pkg.sv
hw/rtl/rfsm_channels.sv
hw/rtl/rfsm_front.sv
hw/rtl/rfsm_queue.sv
hw/rtl/rfsm_back.sv
hw/rtl/range_filter_selection_mask_core.sv
hw/rtl/rfsm_checker.sv
bench/range_filter_selection_mask_core_test.sv
